FILE: hdl/rmat_pkg.sv
`default_nettype none

package rmat_pkg;

   // table sizes
   localparam int UNACK_SLOTS = 32;
   localparam int SEEN_SLOTS  = 64;

   // address and counter widths
   localparam int SLOT_AW  = (UNACK_SLOTS > 1) ? $clog2(UNACK_SLOTS) : 1;
   localparam int SEEN_AW  = (SEEN_SLOTS > 1) ? $clog2(SEEN_SLOTS) : 1;
   localparam int SEEN_CW  = $clog2(SEEN_SLOTS + 1);
   localparam int SLOT_CW  = $clog2(UNACK_SLOTS + 1);
   localparam int SCAN_CW  = (SEEN_CW > SLOT_CW) ? SEEN_CW : SLOT_CW;

   // field widths
   localparam int ID_W      = 31;
   localparam int IP_W      = 32;
   localparam int PORT_W    = 16;
   localparam int TIME_W    = 32;
   localparam int SLOT_W    = 5;
   localparam int PENDING_W = 6;
   localparam int TMO_W     = 16;

   localparam logic [TMO_W-1:0] TMO_RESET = TMO_W'(2);

   typedef enum logic [1:0] {
      MODE_SEND = 2'd0,
      MODE_ACK  = 2'd1,
      MODE_DATA = 2'd2,
      MODE_TICK = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      KIND_ACCEPTED    = 3'd0,
      KIND_ACK_CLEARED = 3'd1,
      KIND_ACK_UNKNOWN = 3'd2,
      KIND_ACK_NEW     = 3'd3,
      KIND_ACK_DUP     = 3'd4,
      KIND_RETX        = 3'd5,
      KIND_SCAN_DONE   = 3'd6
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SLOT_SCAN,
      ST_SEEN_SCAN
   } state_type;

   typedef struct packed {
      mode_type            mode;
      logic [ID_W-1:0]     msg_id;
      logic [IP_W-1:0]     peer_ip;
      logic [PORT_W-1:0]   peer_port;
      logic [TIME_W-1:0]   now;
   } req_type;

   typedef struct packed {
      kind_type               kind;
      logic [ID_W-1:0]        out_id;
      logic [SLOT_W-1:0]      slot;
      logic [IP_W-1:0]        out_ip;
      logic [PORT_W-1:0]      out_port;
      logic                   table_full;
      logic [PENDING_W-1:0]   pending_count;
      logic                   last;
   } rsp_type;

   // one entry of the unacknowledged table
   typedef struct packed {
      logic [ID_W-1:0]     msg_id;
      logic [IP_W-1:0]     ip;
      logic [PORT_W-1:0]   port;
      logic [TIME_W-1:0]   stamp;
   } slot_entry_type;

   localparam int SLOT_ENTRY_W = $bits(slot_entry_type);

endpackage

`default_nettype wire

FILE: hdl/rmat_ram.sv
`default_nettype none

module rmat_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

FILE: hdl/reliable_message_ack_tracker_unit.sv
`default_nettype none

// Acknowledgement tracker for a reliable datagram layer. An item is taken when start is high
// and busy is low. A send never raises busy, so a new item may follow in the next cycle. An
// ack or a timer tick walks the unacknowledged table through its memory read port, one entry
// a cycle, and keeps busy high for the walk, the memory read latency and the closing result;
// a received data item walks the seen-id memory up to its fill count in the same way, or
// skips the walk while that table is still empty. Each result is shown for one cycle under
// rsp_strobe and cannot be held off: the receiver must take it then. A tick gives one
// retransmit result per expired slot, one a cycle, and ends with scan_done (last high). The
// timeout register is written through csr_valid and csr_data, always ready; the user must
// write it only while the block is idle, which the block itself does not enforce.

module reliable_message_ack_tracker_unit (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output logic                             busy,
   input  wire rmat_pkg::req_type           req_item,
   output logic                             rsp_strobe,
   output rmat_pkg::rsp_type                rsp_item,
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic [rmat_pkg::TMO_W-1:0]  csr_data
);

   import rmat_pkg::*;

   // control and bookkeeping registers
   state_type               state_ff, state_in;
   logic [TMO_W-1:0]        timeout_ff;
   logic [ID_W-1:0]         next_id_ff, next_id_in;
   logic [UNACK_SLOTS-1:0]  valid_ff, valid_in;
   logic [PENDING_W-1:0]    pending_ff, pending_in;
   logic [SEEN_CW-1:0]      seen_count_ff, seen_count_in;
   logic [SCAN_CW-1:0]      rd_addr_ff, rd_addr_in;
   logic                    proc_vld_ff, proc_vld_in;
   logic [SCAN_CW-1:0]      proc_addr_ff, proc_addr_in;
   logic                    found_ff, found_in;
   logic [SLOT_AW-1:0]      first_ff, first_in;
   logic                    rsp_strobe_ff, rsp_strobe_in;

   // payload registers
   req_type                 req_ff, req_in;
   rsp_type                 rsp_ff, rsp_in;

   // memory ports
   logic                    slot_wr_en;
   logic [SLOT_AW-1:0]      slot_wr_addr;
   slot_entry_type          slot_wr_data;
   logic [SLOT_ENTRY_W-1:0] slot_rd_bits;
   slot_entry_type          slot_rd;
   logic                    seen_wr_en;
   logic [SEEN_AW-1:0]      seen_wr_addr;
   logic [ID_W-1:0]         seen_rd;

   // free slot search
   logic                    free_ok;
   logic [SLOT_AW-1:0]      free_idx;

   // scan helpers
   logic [SLOT_AW-1:0]      proc_slot;
   logic [TIME_W-1:0]       age;
   logic                    issue;

   assign slot_rd   = slot_entry_type'(slot_rd_bits);
   assign proc_slot = proc_addr_ff[SLOT_AW-1:0];
   assign age       = req_ff.now - slot_rd.stamp;

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;
   assign csr_ready  = 1'b1;

   rmat_ram #(
      .WIDTH (SLOT_ENTRY_W),
      .DEPTH (UNACK_SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_wr_en),
      .wr_addr (slot_wr_addr),
      .wr_data (slot_wr_data),
      .rd_addr (rd_addr_ff[SLOT_AW-1:0]),
      .rd_data (slot_rd_bits)
   );

   rmat_ram #(
      .WIDTH (ID_W),
      .DEPTH (SEEN_SLOTS)
   ) u_seen_ram (
      .clock   (clock),
      .wr_en   (seen_wr_en),
      .wr_addr (seen_wr_addr),
      .wr_data (req_ff.msg_id),
      .rd_addr (rd_addr_ff[SEEN_AW-1:0]),
      .rd_data (seen_rd)
   );

   // lowest free slot
   always_comb begin
      free_ok  = 1'b0;
      free_idx = '0;
      for (int i = UNACK_SLOTS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_ok  = 1'b1;
            free_idx = SLOT_AW'(i);
         end
      end
   end

   // sequencer: next state, memory accesses and result assembly
   always_comb begin
      state_in      = state_ff;
      next_id_in    = next_id_ff;
      valid_in      = valid_ff;
      pending_in    = pending_ff;
      seen_count_in = seen_count_ff;
      rd_addr_in    = rd_addr_ff;
      proc_vld_in   = 1'b0;
      proc_addr_in  = rd_addr_ff;
      found_in      = found_ff;
      first_in      = first_ff;
      req_in        = req_ff;
      rsp_strobe_in = 1'b0;
      issue         = 1'b0;

      slot_wr_en    = 1'b0;
      slot_wr_addr  = proc_slot;
      slot_wr_data  = slot_rd;
      seen_wr_en    = 1'b0;
      seen_wr_addr  = seen_count_ff[SEEN_AW-1:0];

      rsp_in               = '0;
      rsp_in.kind          = KIND_ACCEPTED;
      rsp_in.last          = 1'b1;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in     = req_item;
               rd_addr_in = '0;
               found_in   = 1'b0;
               first_in   = '0;
               case (req_item.mode)
                  MODE_SEND: begin
                     // claim the lowest free slot, or report the table full
                     rsp_strobe_in   = 1'b1;
                     rsp_in.kind     = KIND_ACCEPTED;
                     rsp_in.out_ip   = req_item.peer_ip;
                     rsp_in.out_port = req_item.peer_port;
                     if (free_ok) begin
                        slot_wr_en            = 1'b1;
                        slot_wr_addr          = free_idx;
                        slot_wr_data.msg_id   = next_id_ff;
                        slot_wr_data.ip       = req_item.peer_ip;
                        slot_wr_data.port     = req_item.peer_port;
                        slot_wr_data.stamp    = req_item.now;
                        valid_in[free_idx]    = 1'b1;
                        pending_in            = pending_ff + PENDING_W'(1);
                        next_id_in            = next_id_ff + ID_W'(1);
                        rsp_in.out_id         = next_id_ff;
                        rsp_in.slot           = SLOT_W'(free_idx);
                     end else begin
                        rsp_in.table_full = 1'b1;
                     end
                  end
                  MODE_ACK, MODE_TICK: begin
                     state_in = ST_SLOT_SCAN;
                  end
                  MODE_DATA: begin
                     state_in = ST_SEEN_SCAN;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end

         ST_SLOT_SCAN: begin
            // issue one read a cycle, handle the entry read the cycle before
            issue = (rd_addr_ff < SCAN_CW'(UNACK_SLOTS));
            if (issue) begin
               rd_addr_in  = rd_addr_ff + SCAN_CW'(1);
               proc_vld_in = 1'b1;
            end
            if (proc_vld_ff && valid_ff[proc_slot]) begin
               if (req_ff.mode == MODE_TICK) begin
                  if (age >= TIME_W'(timeout_ff)) begin
                     slot_wr_en         = 1'b1;
                     slot_wr_data.stamp = req_ff.now;
                     rsp_strobe_in      = 1'b1;
                     rsp_in.kind        = KIND_RETX;
                     rsp_in.out_id      = slot_rd.msg_id;
                     rsp_in.slot        = SLOT_W'(proc_slot);
                     rsp_in.out_ip      = slot_rd.ip;
                     rsp_in.out_port    = slot_rd.port;
                     rsp_in.last        = 1'b0;
                  end
               end else if (slot_rd.msg_id == req_ff.msg_id) begin
                  valid_in[proc_slot] = 1'b0;
                  if (pending_ff != '0) begin
                     pending_in = pending_ff - PENDING_W'(1);
                  end
                  if (!found_ff) begin
                     first_in = proc_slot;
                  end
                  found_in = 1'b1;
               end
            end
            // final result once the last entry is handled
            if (!issue && !proc_vld_ff) begin
               state_in      = ST_IDLE;
               rsp_strobe_in = 1'b1;
               if (req_ff.mode == MODE_TICK) begin
                  rsp_in.kind = KIND_SCAN_DONE;
               end else begin
                  rsp_in.kind   = found_ff ? KIND_ACK_CLEARED : KIND_ACK_UNKNOWN;
                  rsp_in.out_id = req_ff.msg_id;
                  rsp_in.slot   = SLOT_W'(first_ff);
               end
            end
         end

         ST_SEEN_SCAN: begin
            // walk the filled part of the seen table looking for the id
            issue = (rd_addr_ff < SCAN_CW'(seen_count_ff));
            if (issue) begin
               rd_addr_in  = rd_addr_ff + SCAN_CW'(1);
               proc_vld_in = 1'b1;
            end
            if (proc_vld_ff && (seen_rd == req_ff.msg_id)) begin
               found_in = 1'b1;
            end
            if (!issue && !proc_vld_ff) begin
               state_in        = ST_IDLE;
               rsp_strobe_in   = 1'b1;
               rsp_in.out_id   = req_ff.msg_id;
               rsp_in.out_ip   = req_ff.peer_ip;
               rsp_in.out_port = req_ff.peer_port;
               if (found_ff) begin
                  rsp_in.kind = KIND_ACK_DUP;
               end else begin
                  rsp_in.kind = KIND_ACK_NEW;
                  if (seen_count_ff < SEEN_CW'(SEEN_SLOTS)) begin
                     seen_wr_en    = 1'b1;
                     seen_count_in = seen_count_ff + SEEN_CW'(1);
                  end else begin
                     rsp_in.table_full = 1'b1;
                  end
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_in.pending_count = pending_in;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         timeout_ff    <= TMO_RESET;
         next_id_ff    <= '0;
         valid_ff      <= '0;
         pending_ff    <= '0;
         seen_count_ff <= '0;
         rd_addr_ff    <= '0;
         proc_vld_ff   <= 1'b0;
         found_ff      <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         next_id_ff    <= next_id_in;
         valid_ff      <= valid_in;
         pending_ff    <= pending_in;
         seen_count_ff <= seen_count_in;
         rd_addr_ff    <= rd_addr_in;
         proc_vld_ff   <= proc_vld_in;
         found_ff      <= found_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_valid && csr_ready) begin
            timeout_ff <= csr_data;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      rsp_ff       <= rsp_in;
      proc_addr_ff <= proc_addr_in;
      first_ff     <= first_in;
   end

endmodule

`default_nettype wire

FILE: tb/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import rmat_pkg::*;

   // directed stimulus row: item plus an optional hand-written expectation
   typedef struct {
      req_type item;
      bit      typed;
      rsp_type want;
   } vector_row_type;

   logic              clock      = 1'b0;
   logic              reset      = 1'b1;
   logic              start      = 1'b0;
   logic              busy;
   req_type           req_item   = '0;
   logic              rsp_strobe;
   rsp_type           rsp_item;
   logic              csr_valid  = 1'b0;
   logic              csr_ready;
   logic [TMO_W-1:0]  csr_data   = '0;

   // mirror of the unacknowledged table
   logic              held_valid [UNACK_SLOTS] = '{default: 1'b0};
   logic [ID_W-1:0]   held_id    [UNACK_SLOTS];
   logic [IP_W-1:0]   held_ip    [UNACK_SLOTS];
   logic [PORT_W-1:0] held_port  [UNACK_SLOTS];
   logic [TIME_W-1:0] held_stamp [UNACK_SLOTS];
   int                pend_cnt   = 0;
   logic [ID_W-1:0]   next_id    = '0;

   // mirror of the seen-id table
   logic [ID_W-1:0]   heard_ids  [SEEN_SLOTS];
   int                heard_cnt  = 0;

   logic [TMO_W-1:0]  tmo_val    = TMO_RESET;

   rsp_type           replies_due [$];
   vector_row_type    dir_rows    [$];
   bit                row_typed  = 1'b0;
   rsp_type           row_want   = '0;
   int                mismatches = 0;
   int                idle_pct   = 38;
   int                now_stride = 3;
   logic [TIME_W-1:0] wall_now   = '0;

   reliable_message_ack_tracker_unit dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #10 clock = ~clock;

   task automatic note_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 100) begin
         $display("mismatch at %0t ns: %s", $time, msg);
      end
   endtask

   // work out the results of one item and advance the mirrored tables
   task automatic compute_replies(input req_type r);
      rsp_type           o;
      int                i;
      int                first;
      bit                hit;
      logic [TIME_W-1:0] age;
      o = '0;
      o.last = 1'b1;
      case (r.mode)
         MODE_SEND: begin
            first = -1;
            for (i = 0; i < UNACK_SLOTS; i++) begin
               if (!held_valid[i] && first < 0) first = i;
            end
            o.kind     = KIND_ACCEPTED;
            o.out_ip   = r.peer_ip;
            o.out_port = r.peer_port;
            if (first < 0) begin
               o.table_full = 1'b1;
            end else begin
               held_valid[first] = 1'b1;
               held_id[first]    = next_id;
               held_ip[first]    = r.peer_ip;
               held_port[first]  = r.peer_port;
               held_stamp[first] = r.now;
               pend_cnt++;
               o.out_id = next_id;
               o.slot   = SLOT_W'(first);
               next_id  = next_id + 1'b1;
            end
            o.pending_count = PENDING_W'(pend_cnt);
            replies_due.push_back(o);
         end
         MODE_ACK: begin
            hit   = 1'b0;
            first = 0;
            for (i = 0; i < UNACK_SLOTS; i++) begin
               if (held_valid[i] && held_id[i] == r.msg_id) begin
                  if (!hit) first = i;
                  hit = 1'b1;
                  held_valid[i] = 1'b0;
                  if (pend_cnt > 0) pend_cnt--;
               end
            end
            o.kind          = hit ? KIND_ACK_CLEARED : KIND_ACK_UNKNOWN;
            o.out_id        = r.msg_id;
            o.slot          = SLOT_W'(first);
            o.pending_count = PENDING_W'(pend_cnt);
            replies_due.push_back(o);
         end
         MODE_DATA: begin
            hit = 1'b0;
            for (i = 0; i < heard_cnt; i++) begin
               if (heard_ids[i] == r.msg_id) hit = 1'b1;
            end
            o.out_id   = r.msg_id;
            o.out_ip   = r.peer_ip;
            o.out_port = r.peer_port;
            if (hit) begin
               o.kind = KIND_ACK_DUP;
            end else begin
               o.kind = KIND_ACK_NEW;
               if (heard_cnt < SEEN_SLOTS) begin
                  heard_ids[heard_cnt] = r.msg_id;
                  heard_cnt++;
               end else begin
                  o.table_full = 1'b1;
               end
            end
            o.pending_count = PENDING_W'(pend_cnt);
            replies_due.push_back(o);
         end
         default: begin
            // timer tick: every expired slot in ascending order, then the end marker
            for (i = 0; i < UNACK_SLOTS; i++) begin
               age = r.now - held_stamp[i];
               if (held_valid[i] && age >= {16'h0000, tmo_val}) begin
                  o               = '0;
                  o.kind          = KIND_RETX;
                  o.out_id        = held_id[i];
                  o.slot          = SLOT_W'(i);
                  o.out_ip        = held_ip[i];
                  o.out_port      = held_port[i];
                  o.pending_count = PENDING_W'(pend_cnt);
                  replies_due.push_back(o);
                  held_stamp[i] = r.now;
               end
            end
            o               = '0;
            o.kind          = KIND_SCAN_DONE;
            o.pending_count = PENDING_W'(pend_cnt);
            o.last          = 1'b1;
            replies_due.push_back(o);
         end
      endcase
   endtask

   task automatic check_reply(input rsp_type got, input rsp_type want);
      if (got.kind !== want.kind)
         note_mismatch($sformatf("kind %0d, wanted %0d", got.kind, want.kind));
      if (got.out_id !== want.out_id)
         note_mismatch($sformatf("out_id %h, wanted %h", got.out_id, want.out_id));
      if (got.slot !== want.slot)
         note_mismatch($sformatf("slot %0d, wanted %0d", got.slot, want.slot));
      if (got.out_ip !== want.out_ip)
         note_mismatch($sformatf("out_ip %h, wanted %h", got.out_ip, want.out_ip));
      if (got.out_port !== want.out_port)
         note_mismatch($sformatf("out_port %h, wanted %h", got.out_port, want.out_port));
      if (got.table_full !== want.table_full)
         note_mismatch($sformatf("table_full %b, wanted %b", got.table_full,
                                 want.table_full));
      if (got.pending_count !== want.pending_count)
         note_mismatch($sformatf("pending_count %0d, wanted %0d", got.pending_count,
                                 want.pending_count));
      if (got.last !== want.last)
         note_mismatch($sformatf("last %b, wanted %b", got.last, want.last));
   endtask

   // acceptance, register writes and results, all seen at the rising edge
   always @(posedge clock) begin : watch_results
      rsp_type want;
      if (!reset) begin
         if (csr_valid && csr_ready) tmo_val = csr_data;
         if (start && !busy) begin
            compute_replies(req_item);
            if (row_typed) begin
               void'(replies_due.pop_back());
               replies_due.push_back(row_want);
            end
         end
         if (rsp_strobe) begin
            if (replies_due.size() == 0) begin
               note_mismatch($sformatf("result kind %0d with nothing pending",
                                       rsp_item.kind));
            end else begin
               want = replies_due.pop_front();
               check_reply(rsp_item, want);
            end
         end
      end
   end

   function automatic vector_row_type mk_row(input mode_type m, input logic [ID_W-1:0] id,
                                        input logic [IP_W-1:0] ip,
                                        input logic [PORT_W-1:0] port,
                                        input logic [TIME_W-1:0] stamp, input bit typed,
                                        input kind_type k, input logic [ID_W-1:0] oid,
                                        input logic [SLOT_W-1:0] sl,
                                        input logic [IP_W-1:0] oip,
                                        input logic [PORT_W-1:0] oport,
                                        input logic [PENDING_W-1:0] pend);
      vector_row_type v;
      v.item.mode      = m;
      v.item.msg_id    = id;
      v.item.peer_ip   = ip;
      v.item.peer_port = port;
      v.item.now       = stamp;
      v.typed          = typed;
      v.want           = '0;
      v.want.kind          = k;
      v.want.out_id        = oid;
      v.want.slot          = sl;
      v.want.out_ip        = oip;
      v.want.out_port      = oport;
      v.want.pending_count = pend;
      v.want.last          = 1'b1;
      return v;
   endfunction

   // random event, biased towards ids that the tables actually hold
   function automatic req_type random_event();
      req_type r;
      int      pick;
      int      k;
      int      i;
      int      j;
      bit      found;
      r.msg_id    = ID_W'($urandom);
      r.peer_ip   = $urandom;
      r.peer_port = PORT_W'($urandom);
      if ($urandom_range(99) < 3) wall_now = $urandom;
      else wall_now = wall_now + $urandom_range(now_stride);
      r.now = wall_now;
      pick = $urandom_range(99);
      if (pick < 35) begin
         r.mode = MODE_SEND;
      end else if (pick < 60) begin
         r.mode = MODE_ACK;
         if (pend_cnt > 0 && $urandom_range(99) < 75) begin
            k     = $urandom_range(UNACK_SLOTS - 1);
            found = 1'b0;
            for (i = 0; i < UNACK_SLOTS; i++) begin
               j = (k + i) % UNACK_SLOTS;
               if (!found && held_valid[j]) begin
                  r.msg_id = held_id[j];
                  found    = 1'b1;
               end
            end
         end
      end else if (pick < 80) begin
         r.mode = MODE_DATA;
         if (heard_cnt > 0 && $urandom_range(99) < 35)
            r.msg_id = heard_ids[$urandom_range(heard_cnt - 1)];
      end else begin
         r.mode = MODE_TICK;
      end
      return r;
   endfunction

   // present one item and hold it until the block takes it
   task automatic issue(input req_type r, input bit typed, input rsp_type want);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      row_typed = typed;
      row_want  = want;
      start    <= 1'b1;
      req_item <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain_replies();
      start <= 1'b0;
      @(negedge clock);
      while (replies_due.size() != 0 || busy) @(negedge clock);
   endtask

   task automatic write_timeout(input logic [TMO_W-1:0] value);
      drain_replies();
      // drain_replies already waits for busy to fall, so no scan is still running here
      repeat (40) @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      int      ph;
      int      n;
      int      w;
      req_type r;

      // timeout 2 after reset: directed walk through every event kind
      dir_rows.push_back(mk_row(MODE_TICK, '0, '0, '0, '0, 1,
                                KIND_SCAN_DONE, '0, '0, '0, '0, 6'd0));
      dir_rows.push_back(mk_row(MODE_ACK, 31'd5, '0, '0, '0, 1,
                                KIND_ACK_UNKNOWN, 31'd5, '0, '0, '0, 6'd0));
      dir_rows.push_back(mk_row(MODE_DATA, '1, '1, '1, '0, 1,
                                KIND_ACK_NEW, '1, '0, '1, '1, 6'd0));
      dir_rows.push_back(mk_row(MODE_DATA, '1, '1, '1, '0, 1,
                                KIND_ACK_DUP, '1, '0, '1, '1, 6'd0));
      dir_rows.push_back(mk_row(MODE_DATA, '0, '0, '0, '0, 1,
                                KIND_ACK_NEW, '0, '0, '0, '0, 6'd0));
      dir_rows.push_back(mk_row(MODE_SEND, '1, '1, '1, '1, 1,
                                KIND_ACCEPTED, 31'd0, 5'd0, '1, '1, 6'd1));
      dir_rows.push_back(mk_row(MODE_SEND, '0, '0, '0, '0, 1,
                                KIND_ACCEPTED, 31'd1, 5'd1, '0, '0, 6'd2));
      // slot 0 has aged past the wrap, slot 1 not yet
      dir_rows.push_back(mk_row(MODE_TICK, '0, '0, '0, 32'd1, 0,
                                KIND_ACCEPTED, '0, '0, '0, '0, '0));
      dir_rows.push_back(mk_row(MODE_TICK, '0, '0, '0, 32'd2, 0,
                                KIND_ACCEPTED, '0, '0, '0, '0, '0));
      dir_rows.push_back(mk_row(MODE_ACK, 31'd0, '1, '1, '0, 1,
                                KIND_ACK_CLEARED, 31'd0, 5'd0, '0, '0, 6'd1));
      dir_rows.push_back(mk_row(MODE_SEND, '0, 32'h0A00_0001, 16'h0050, 32'd5, 1,
                                KIND_ACCEPTED, 31'd2, 5'd0, 32'h0A00_0001, 16'h0050, 6'd2));
      dir_rows.push_back(mk_row(MODE_ACK, 31'd1, '0, '0, '0, 1,
                                KIND_ACK_CLEARED, 31'd1, 5'd1, '0, '0, 6'd1));
      // second ack for the same id finds nothing
      dir_rows.push_back(mk_row(MODE_ACK, 31'd1, '0, '0, '0, 1,
                                KIND_ACK_UNKNOWN, 31'd1, 5'd0, '0, '0, 6'd1));
      // time running backwards reads as a very old entry
      dir_rows.push_back(mk_row(MODE_TICK, '0, '0, '0, 32'd1, 0,
                                KIND_ACCEPTED, '0, '0, '0, '0, '0));
      dir_rows.push_back(mk_row(MODE_TICK, '0, '0, '0, 32'd1, 0,
                                KIND_ACCEPTED, '0, '0, '0, '0, '0));
      dir_rows.push_back(mk_row(MODE_DATA, 31'h5555_5555, 32'hAAAA_AAAA, 16'h5555, '0, 0,
                                KIND_ACCEPTED, '0, '0, '0, '0, '0));
      dir_rows.push_back(mk_row(MODE_SEND, 31'h2AAA_AAAA, 32'hC0A8_0001, 16'h1F90,
                                32'h8000_0000, 0, KIND_ACCEPTED, '0, '0, '0, '0, '0));
      dir_rows.push_back(mk_row(MODE_TICK, '0, '0, '0, 32'h8000_0001, 0,
                                KIND_ACCEPTED, '0, '0, '0, '0, '0));

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) issue(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
      wall_now = 32'h8000_0001;

      // random phases, one timeout setting each
      for (ph = 0; ph < 5; ph++) begin
         case (ph)
            1:       write_timeout(16'h0000);
            2:       write_timeout(16'hFFFF);
            3:       write_timeout(16'h0001);
            4:       write_timeout(TMO_W'($urandom_range(3, 300)));
            default: ;
         endcase
         idle_pct   = (ph == 3) ? 0 : 38;
         now_stride = (tmo_val > 16'd1000) ? 30000 : 3;

         // fill the unacknowledged table and run over; zero timeout gives full scans
         if (ph == 1) begin
            for (n = 0; pend_cnt < UNACK_SLOTS || n < 2; n += (pend_cnt == UNACK_SLOTS)) begin
               r = random_event();
               r.mode = MODE_SEND;
               issue(r, 1'b0, '0);
            end
         end
         // fill the seen-id table with fresh ids and run over
         if (ph == 3) begin
            for (n = 0; heard_cnt < SEEN_SLOTS || n < 2; n += (heard_cnt == SEEN_SLOTS)) begin
               r = random_event();
               r.mode = MODE_DATA;
               issue(r, 1'b0, '0);
            end
         end

         for (n = 0; n < 76; n++) begin
            if (ph == 0 && n == 40) drain_replies();
            issue(random_event(), 1'b0, '0);
         end
      end

      // let everything in flight come out
      start <= 1'b0;
      for (w = 0; w < 5000 && replies_due.size() != 0; w++) @(negedge clock);
      repeat (40) @(negedge clock);
      if (replies_due.size() != 0)
         note_mismatch($sformatf("%0d results never arrived", replies_due.size()));

      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // watchdog, far beyond the slowest legal run of the stimulus above
   initial begin
      #20_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule

FILE: reliable_message_ack_tracker_unit.f
hdl/rmat_pkg.sv
hdl/rmat_ram.sv
hdl/reliable_message_ack_tracker_unit.sv
tb/testbench.sv
